// ===== src/batch_job_schedule_fcfs_sjf_assert.svh =====
// Assertion macros for the batch job scheduler
`ifndef BATCH_JOB_SCHEDULE_FCFS_SJF_ASSERT_SVH
`define BATCH_JOB_SCHEDULE_FCFS_SJF_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BJS_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define BJS_ASSERT_STABLE(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> $stable(sig)) else $error("signal not stable");
`else
`define BJS_ASSERT_IMPL(lbl, clk, rstn, prop)
`define BJS_ASSERT_STABLE(lbl, clk, rstn, cond, sig)
`endif
`endif

// ===== src/bjs_pkg.sv =====
// Package: types and constants for the batch job scheduler
package bjs_pkg;
  localparam int unsigned MaxJobsDef = 64;
  localparam int unsigned TimeW = 23;
  localparam int unsigned WtW = 24;
  localparam logic [WtW-1:0] WtMax = '1;

  typedef struct packed {
    logic [7:0]  job_tag;
    logic [15:0] arrive_time;
    logic [15:0] serve_time;
    logic        last_job;
  } job_t;

  typedef struct packed {
    logic [7:0]       out_tag;
    logic [TimeW-1:0] finish_time;
    logic [TimeW-1:0] turnaround;
    logic [WtW-1:0]   weighted_turnaround;
    logic             batch_last;
  } res_t;
endpackage

// ===== src/bjs_job_if.sv =====
// Interface: job input channel
interface bjs_job_if import bjs_pkg::*; ();
  logic valid;
  logic ready;
  job_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bjs_res_if.sv =====
// Interface: result channel
interface bjs_res_if import bjs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bjs_cfg_if.sv =====
// Interface: policy configuration write channel
interface bjs_cfg_if ();
  logic valid;
  logic ready;
  logic policy_mode;
  modport source (output valid, output policy_mode, input ready);
  modport sink (input valid, input policy_mode, output ready);
endinterface

// ===== src/batch_job_schedule_fcfs_sjf.sv =====
// Batch job scheduler, FCFS and SJF, non-preemptive.
// Channels: job_in (sink) takes one job per transaction; the job with
// last_job set closes the batch. res_out (source) gives one result per
// job in completion order, batch_last on the final one. cfg (sink)
// writes policy_mode; the value in force at the last job is used.
// Loading stores each accepted job in the job memory. After the last
// job, each result takes one scan of the job memory (one entry per
// cycle), a fetch of the picked job, a restoring divide for the
// weighted turnaround and a registered output state.
// The memory port sets the scan rate. Jobs beyond MAX_JOBS are dropped.
// Reset clears the batch and policy; the memories need no clearing.
// A stalled receiver holds the result register; the scan for the next
// job does not begin until the result is taken.
module batch_job_schedule_fcfs_sjf import bjs_pkg::*; #(
  parameter int unsigned MAX_JOBS = MaxJobsDef
) (
  input logic clk_i,
  input logic rst_ni,
  bjs_job_if.sink job_in,
  bjs_res_if.source res_out,
  bjs_cfg_if.sink cfg
);
`include "batch_job_schedule_fcfs_sjf_assert.svh"
  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [7:0]  tag_mem [MAX_JOBS];
  logic [15:0] arr_mem [MAX_JOBS];
  logic [15:0] srv_mem [MAX_JOBS];

  logic [2:0] state_q;
  logic [MAX_JOBS-1:0] pend_q;
  logic [CW-1:0] cnt_q, done_q, scan_q;
  logic [TimeW-1:0] clk_q;
  logic pol_q, bpol_q;
  logic rd_v_q;
  logic [IW-1:0] rd_idx_q;
  logic [7:0] rd_tag_q;
  logic [15:0] rd_arr_q, rd_srv_q;
  logic e_v_q, s_v_q;
  logic [IW-1:0] e_idx_q, s_idx_q;
  logic [15:0] e_arr_q, s_srv_q;
  logic [7:0] pk_tag_q;
  logic [15:0] pk_arr_q, pk_srv_q;
  logic [IW-1:0] pk_idx_q;
  logic [5:0] div_cnt_q;
  logic [31:0] num_q;
  logic [16:0] rem_q;
  logic [31:0] quo_q;
  res_t res_q;
  logic res_v_q;

  logic load_fire;
  logic [IW-1:0] scan_idx;
  logic arrived;
  logic [TimeW-1:0] start, fin;
  logic [16:0] rem_sh;
  logic [TimeW-1:0] turn;

  assign job_in.ready = (state_q == S_LOAD);
  assign cfg.ready = 1'b1;
  assign load_fire = job_in.valid && job_in.ready;
  assign scan_idx = scan_q[IW-1:0];
  assign arrived = ({7'd0, rd_arr_q} <= clk_q);
  assign start = (clk_q > {7'd0, pk_arr_q}) ? clk_q : {7'd0, pk_arr_q};
  assign fin = start + {7'd0, pk_srv_q};
  assign turn = fin - {7'd0, pk_arr_q};
  assign rem_sh = {rem_q[15:0], num_q[31]};
  assign res_out.valid = res_v_q;
  assign res_out.data = res_q;

  always_ff @(posedge clk_i) begin
    if (load_fire && (cnt_q < CW'(MAX_JOBS))) begin
      tag_mem[cnt_q[IW-1:0]] <= job_in.data.job_tag;
      arr_mem[cnt_q[IW-1:0]] <= job_in.data.arrive_time;
      srv_mem[cnt_q[IW-1:0]] <= job_in.data.serve_time;
    end
    rd_tag_q <= tag_mem[scan_idx];
    rd_arr_q <= arr_mem[scan_idx];
    rd_srv_q <= srv_mem[scan_idx];
    rd_idx_q <= scan_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      pend_q <= '0;
      cnt_q <= '0;
      done_q <= '0;
      scan_q <= '0;
      clk_q <= '0;
      pol_q <= 1'b0;
      bpol_q <= 1'b0;
      rd_v_q <= 1'b0;
      e_v_q <= 1'b0;
      s_v_q <= 1'b0;
      res_v_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cfg.valid) pol_q <= cfg.policy_mode;
      if (res_v_q && res_out.ready) res_v_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (load_fire) begin
            if (cnt_q < CW'(MAX_JOBS)) begin
              cnt_q <= cnt_q + 1'b1;
              pend_q[cnt_q[IW-1:0]] <= 1'b1;
            end
            if (job_in.data.last_job) begin
              bpol_q <= pol_q;
              clk_q <= '0;
              done_q <= '0;
              scan_q <= '0;
              rd_v_q <= 1'b0;
              e_v_q <= 1'b0;
              s_v_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!res_v_q) begin
            if (done_q == cnt_q) begin
              pend_q <= '0;
              cnt_q <= '0;
              done_q <= '0;
              clk_q <= '0;
              state_q <= S_LOAD;
            end else begin
              rd_v_q <= (scan_q < cnt_q);
              if (scan_q < cnt_q) scan_q <= scan_q + 1'b1;
              if (rd_v_q && pend_q[rd_idx_q]) begin
                if (!e_v_q || rd_arr_q < e_arr_q) begin
                  e_v_q <= 1'b1; e_idx_q <= rd_idx_q; e_arr_q <= rd_arr_q;
                end
                if (arrived && (!s_v_q || rd_srv_q < s_srv_q)) begin
                  s_v_q <= 1'b1; s_idx_q <= rd_idx_q; s_srv_q <= rd_srv_q;
                end
              end
              if (!rd_v_q && scan_q == cnt_q && scan_q != '0) begin
                pk_idx_q <= (bpol_q && s_v_q) ? s_idx_q : e_idx_q;
                scan_q <= {1'b0, ((bpol_q && s_v_q) ? s_idx_q : e_idx_q)};
                state_q <= S_PICK;
              end
            end
          end
        end
        S_PICK: begin
          pk_tag_q <= rd_tag_q;
          pk_arr_q <= rd_arr_q;
          pk_srv_q <= rd_srv_q;
          if (rd_idx_q == pk_idx_q && rd_v_q == 1'b0 && scan_q == {1'b0, pk_idx_q}) begin
            rd_v_q <= 1'b1;
          end else if (rd_v_q) begin
            rd_v_q <= 1'b0;
            state_q <= S_DIV;
            div_cnt_q <= '0;
            rem_q <= '0;
            quo_q <= '0;
          end
        end
        S_DIV: begin
          if (div_cnt_q == 6'd0) begin
            num_q <= {1'b0, turn, 8'd0};
            div_cnt_q <= 6'd1;
          end else if (div_cnt_q <= 6'd32) begin
            if (rem_sh >= {1'b0, pk_srv_q}) begin
              rem_q <= rem_sh - {1'b0, pk_srv_q};
              quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[30:0], 1'b0};
            end
            num_q <= {num_q[30:0], 1'b0};
            div_cnt_q <= div_cnt_q + 1'b1;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          res_q.out_tag <= pk_tag_q;
          res_q.finish_time <= fin;
          res_q.turnaround <= turn;
          res_q.weighted_turnaround <= (pk_srv_q == '0 || quo_q[31:WtW] != '0) ?
                                       WtMax : quo_q[WtW-1:0];
          res_q.batch_last <= (done_q + 1'b1 == cnt_q);
          res_v_q <= 1'b1;
          clk_q <= fin;
          pend_q[pk_idx_q] <= 1'b0;
          done_q <= done_q + 1'b1;
          scan_q <= '0;
          rd_v_q <= 1'b0;
          e_v_q <= 1'b0;
          s_v_q <= 1'b0;
          state_q <= S_SCAN;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `BJS_ASSERT_STABLE(a_res_hold, clk_i, rst_ni, res_v_q && !res_out.ready, res_q)
  `BJS_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(MAX_JOBS))
  `BJS_ASSERT_IMPL(a_done_range, clk_i, rst_ni, done_q <= cnt_q)
  `BJS_ASSERT_IMPL(a_no_load_busy, clk_i, rst_ni, state_q != S_LOAD |-> !job_in.ready)
endmodule
